FILE: hdl/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: hdl/kaf_pkg.sv
// shared types and constants of the angle filter
package kaf_pkg;

   localparam int DataW  = 32;
   localparam int DtW    = 25;
   localparam int MnoiseW = 29;
   localparam int CsrW   = 29;
   localparam int FracBits = 24;
   localparam logic signed [31:0] OneQ24 = 32'sd16777216;

   localparam logic [1:0] CsrAngleNoise = 2'd0;
   localparam logic [1:0] CsrBiasNoise  = 2'd1;
   localparam logic [1:0] CsrMeasNoise  = 2'd2;

   // divider control between sequencer and division unit
   typedef struct packed {
      logic               start;
      logic signed [63:0] num;
      logic        [63:0] den;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic signed [63:0] quo;
   } div_rsp_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
      logic signed [31:0] r;
      if (x > 66'sd2147483647) r = 32'sh7fffffff;
      else if (x < -66'sd2147483648) r = 32'sh80000000;
      else r = x[31:0];
      return r;
   endfunction

   // round to nearest, ties toward plus infinity, by 2^24
   function automatic logic signed [65:0] rescale(input logic signed [65:0] x);
      logic signed [65:0] t;
      t = x + 66'sd8388608;
      return t >>> FracBits;
   endfunction

endpackage

FILE: hdl/kalman_angle_filter_core.sv
// Two-state Kalman filter (angle and gyro bias) over a shared multiplier and divider.
// An item passes from one acceptance to the next through four predict steps, one setup
// step, two 64-step restoring divisions with a start step for the second, six update
// steps, one output step and one idle step. The ten multiply steps share one 33x40
// multiplier with rescale; all products but dt * p11 are then saturated. When the
// innovation variance is not positive the divisions and the update are skipped.
// req_ready is high only while idle. The result sits in an output register, so the
// next item is taken while it waits, and a finished item holds in the output step
// until that register is free.
module kalman_angle_filter_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [kaf_pkg::DataW-1:0]  req_measured_angle,
   input  logic signed [kaf_pkg::DataW-1:0]  req_gyro_rate,
   input  logic        [kaf_pkg::DtW-1:0]    req_time_step,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [kaf_pkg::DataW-1:0]  rsp_filtered_angle,
   output logic signed [kaf_pkg::DataW-1:0]  rsp_estimated_bias,
   input  logic                              csr_write,
   input  logic        [1:0]                 csr_index,
   input  logic        [kaf_pkg::CsrW-1:0]   csr_data
);
   import kaf_pkg::*;
   `include "assert_macros.svh"

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b00000001,
      ST_PRED  = 8'b00000010,
      ST_DIVA  = 8'b00000100,
      ST_WAITA = 8'b00001000,
      ST_WAITB = 8'b00010000,
      ST_UPD   = 8'b00100000,
      ST_OUT   = 8'b01000000,
      ST_DIVB  = 8'b10000000
   } state_type;

   state_type state_ff, state_in;
   logic [3:0] step_ff, step_in;

   logic [DtW-1:0] q_ff, qb_ff;
   logic [MnoiseW-1:0] r_ff;

   logic signed [31:0] ang_ff, ang_in, bias_ff, bias_in;
   logic signed [31:0] p00_ff, p00_in, p01_ff, p01_in, p10_ff, p10_in, p11_ff, p11_in;
   logic signed [31:0] meas_ff, meas_in, rate_ff, rate_in;
   logic [DtW-1:0] dt_ff, dt_in;
   // dt * p11 can exceed the 32-bit range and is kept unsaturated
   logic signed [33:0] t_ff, t_in;
   logic signed [31:0] k0_ff, k0_in, k1_ff, k1_in, y_ff, y_in;
   logic signed [31:0] h00_ff, h00_in, h01_ff, h01_in;
   logic signed [65:0] s_ff, s_in;
   logic rv_ff, rv_in;
   logic signed [31:0] oa_ff, oa_in, ob_ff, ob_in;

   // shared multiplier: 33-bit signed operand by 40-bit signed operand
   logic signed [32:0] ma;
   logic signed [39:0] mb;
   logic signed [72:0] prod;
   logic signed [65:0] rs;

   div_req_type dreq;
   div_rsp_type drsp;

   kaf_divider u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   always_comb begin
      ma = '0;
      mb = '0;
      unique case (step_ff)
         4'd0: begin ma = {8'd0, dt_ff}; mb = 40'(rate_ff) - 40'(bias_ff); end
         4'd1: begin ma = {8'd0, dt_ff}; mb = 40'(p11_ff); end
         4'd2: begin
            ma = {8'd0, dt_ff};
            mb = 40'(t_ff) - 40'(p01_ff) - 40'(p10_ff) + 40'({1'b0, q_ff});
         end
         4'd3: begin ma = {8'd0, dt_ff}; mb = 40'({1'b0, qb_ff}); end
         4'd4: begin ma = 33'(k0_ff); mb = 40'(y_ff); end
         4'd5: begin ma = 33'(k1_ff); mb = 40'(y_ff); end
         4'd6: begin ma = 33'(k0_ff); mb = 40'(h00_ff); end
         4'd7: begin ma = 33'(k0_ff); mb = 40'(h01_ff); end
         4'd8: begin ma = 33'(k1_ff); mb = 40'(h00_ff); end
         4'd9: begin ma = 33'(k1_ff); mb = 40'(h01_ff); end
         default: begin ma = '0; mb = '0; end
      endcase
      prod = ma * mb;
      rs = rescale(prod[65:0]);
   end

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      ang_in = ang_ff; bias_in = bias_ff;
      p00_in = p00_ff; p01_in = p01_ff; p10_in = p10_ff; p11_in = p11_ff;
      meas_in = meas_ff; rate_in = rate_ff; dt_in = dt_ff;
      t_in = t_ff; k0_in = k0_ff; k1_in = k1_ff; y_in = y_ff;
      h00_in = h00_ff; h01_in = h01_ff; s_in = s_ff;
      rv_in = rv_ff; oa_in = oa_ff; ob_in = ob_ff;
      dreq.start = 1'b0;
      dreq.num = '0;
      dreq.den = s_ff[63:0];
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               meas_in = req_measured_angle;
               rate_in = req_gyro_rate;
               dt_in = req_time_step;
               step_in = 4'd0;
               state_in = ST_PRED;
            end
         end
         ST_PRED: begin
            unique case (step_ff)
               4'd0: begin ang_in = sat32(66'(ang_ff) + rs); step_in = 4'd1; end
               4'd1: begin t_in = rs[33:0]; step_in = 4'd2; end
               4'd2: begin
                  // p01 and p10 still hold their prior values here
                  p00_in = sat32(66'(p00_ff) + rs);
                  step_in = 4'd3;
               end
               default: begin
                  p01_in = sat32(66'(p01_ff) - 66'(t_ff));
                  p10_in = sat32(66'(p10_ff) - 66'(t_ff));
                  p11_in = sat32(66'(p11_ff) + rs);
                  state_in = ST_DIVA;
               end
            endcase
         end
         ST_DIVA: begin
            s_in = 66'(p00_ff) + 66'({1'b0, r_ff});
            y_in = sat32(66'(meas_ff) - 66'(ang_ff));
            h00_in = p00_ff;
            h01_in = p01_ff;
            if (s_in > 66'sd0) begin
               dreq.start = 1'b1;
               dreq.num = 64'(p00_ff) <<< FracBits;
               dreq.den = 64'(p00_ff) + 64'({1'b0, r_ff});
               state_in = ST_WAITA;
            end else state_in = ST_OUT;
         end
         ST_WAITA: begin
            if (drsp.done) begin
               k0_in = sat32(66'(drsp.quo));
               state_in = ST_DIVB;
            end
         end
         ST_DIVB: begin
            dreq.start = 1'b1;
            dreq.num = 64'(p10_ff) <<< FracBits;
            state_in = ST_WAITB;
         end
         ST_WAITB: begin
            if (drsp.done) begin
               k1_in = sat32(66'(drsp.quo));
               step_in = 4'd4;
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            step_in = step_ff + 4'd1;
            unique case (step_ff)
               4'd4: ang_in = sat32(66'(ang_ff) + rs);
               4'd5: bias_in = sat32(66'(bias_ff) + rs);
               4'd6: p00_in = sat32(66'(p00_ff) - rs);
               4'd7: p01_in = sat32(66'(p01_ff) - rs);
               4'd8: p10_in = sat32(66'(p10_ff) - rs);
               default: begin
                  p11_in = sat32(66'(p11_ff) - rs);
                  state_in = ST_OUT;
               end
            endcase
         end
         ST_OUT: begin
            // wait here while the previous result is still held
            if (!rv_ff || rsp_ready) begin
               rv_in = 1'b1;
               oa_in = ang_ff;
               ob_in = bias_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff <= '0;
         rv_ff <= 1'b0;
         q_ff <= 25'd16777;
         qb_ff <= 25'd50332;
         r_ff <= 29'd8388608;
         ang_ff <= '0; bias_ff <= '0;
         p00_ff <= OneQ24; p01_ff <= '0; p10_ff <= '0; p11_ff <= OneQ24;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         rv_ff <= rv_in;
         ang_ff <= ang_in; bias_ff <= bias_in;
         p00_ff <= p00_in; p01_ff <= p01_in; p10_ff <= p10_in; p11_ff <= p11_in;
         if (csr_write) begin
            unique case (csr_index)
               CsrAngleNoise: q_ff <= csr_data[DtW-1:0];
               CsrBiasNoise:  qb_ff <= csr_data[DtW-1:0];
               CsrMeasNoise:  r_ff <= csr_data[MnoiseW-1:0];
               default: ;
            endcase
         end
      end
      meas_ff <= meas_in; rate_ff <= rate_in; dt_ff <= dt_in;
      t_ff <= t_in; k0_ff <= k0_in; k1_ff <= k1_in; y_ff <= y_in;
      h00_ff <= h00_in; h01_ff <= h01_in; s_ff <= s_in;
      oa_ff <= oa_in; ob_ff <= ob_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp_filtered_angle = oa_ff;
   assign rsp_estimated_bias = ob_ff;

   `ASSERT_NEXT(a_accept_starts, clock, reset, req_valid && req_ready, state_ff == ST_PRED)
   `ASSERT_IMPL(a_no_accept_busy, clock, reset, state_ff != ST_IDLE, !req_ready)
   `ASSERT_NEXT(a_out_sets_valid, clock, reset, state_ff == ST_OUT, rsp_valid)
endmodule

FILE: hdl/kaf_divider.sv
// restoring divider, magnitude rounded to nearest with ties away from zero
module kaf_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  kaf_pkg::div_req_type req,
   output kaf_pkg::div_rsp_type rsp
);
   import kaf_pkg::*;
   `include "assert_macros.svh"

   logic        [63:0] rem_ff, rem_in;
   logic        [63:0] quo_ff, quo_in;
   logic        [63:0] den_ff, den_in;
   logic               neg_ff, neg_in;
   logic        [6:0]  cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic        [63:0] mag;
   logic        [64:0] trial;
   logic        [64:0] shifted;

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      den_in = den_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      mag = req.num[63] ? (64'd0 - req.num) : req.num;
      shifted = {rem_ff, quo_ff[63]};
      trial = shifted - {1'b0, den_ff};
      if (req.start) begin
         // bias the dividend by half the divisor for rounding
         quo_in = mag + (req.den >> 1);
         rem_in = '0;
         den_in = req.den;
         neg_in = req.num[63];
         cnt_in = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[64]) begin
            rem_in = trial[63:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = shifted[63:0];
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quo = neg_ff ? (64'sd0 - $signed(quo_ff)) : $signed(quo_ff);

   `ASSERT_NEXT(a_done_after_busy, clock, reset, busy_ff && cnt_ff == 7'd1, done_ff)
   `ASSERT_IMPL(a_busy_count, clock, reset, busy_ff, cnt_ff != 7'd0)
endmodule
